// File: sv/pgna_pkg.sv
// ---------------------------------------------------------------------------
// pgna_pkg
// shared types and constants of the particle grid node assignment unit
// ---------------------------------------------------------------------------
package pgna_pkg;

   // register indexes of the csr port
   localparam logic [2:0] CSR_ORIGIN_X  = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y  = 3'd1;
   localparam logic [2:0] CSR_SPACING_X = 3'd2;
   localparam logic [2:0] CSR_SPACING_Y = 3'd3;
   localparam logic [2:0] CSR_RADIUS    = 3'd4;
   localparam logic [2:0] CSR_NODES_X   = 3'd5;
   localparam logic [2:0] CSR_NODES_Y   = 3'd6;

   localparam logic [10:0] NODE_LIMIT = 11'd1024;

   // number of root steps, one per pipeline stage
   localparam int SQRT_STEPS = 32;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [30:0]        spacing_x;
      logic [30:0]        spacing_y;
      logic [10:0]        nodes_x;
      logic [10:0]        nodes_y;
      logic [61:0]        radius_sq;
   } cfg_type;

   // one candidate node as it leaves the window scanner
   typedef struct packed {
      logic               valid;
      logic               end_run;
      logic signed [34:0] node_i;
      logic signed [34:0] node_j;
      logic [31:0]        px;
      logic [31:0]        py;
      logic [19:0]        pid;
   } cand_type;

   // control and identity that travel with a candidate
   typedef struct packed {
      logic        valid;
      logic        hit;
      logic        end_run;
      logic [9:0]  node_i;
      logic [9:0]  node_j;
      logic [19:0] pid;
   } tag_type;

endpackage

// File: sv/particle_grid_node_assignment_unit.sv
// ---------------------------------------------------------------------------
// particle_grid_node_assignment_unit
// reports the grid nodes within a radius of each particle
// ---------------------------------------------------------------------------
// each particle word (x, y in signed q16.16, id) yields a run of result
// words, one per grid node strictly closer than the radius, in scan order
// (window rows outer, columns inner); tlast marks the final word of a run
// and a run may be empty, in which case nothing comes out. the window spans
// (2*WINDOW_REACH+2) nodes per axis around the reference cell, 64 candidates
// at the default reach; one candidate leaves the scanner each cycle while
// the result port is not stalled, and with the default reach that scanner
// sets the sustained rate. the reference cell comes from two serial floor
// dividers, which run for the next particle while the current one is
// scanned. a candidate then passes five distance stages and 32 square
// root stages. a stalled result port freezes the whole candidate
// pipeline. csr writes are taken in the cycle csr_we is high and belong
// in idle periods only.
// ---------------------------------------------------------------------------
module particle_grid_node_assignment_unit #(
   parameter int WINDOW_REACH = 3
) (
   input  logic        clock,
   input  logic        reset,
   // particle word
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,   // particle_x, particle_y, particle_id, zero pad
   // node hit word
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // node_i, node_j, hit_id, distance
   output logic        rsp_tlast,   // last_hit
   // register writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pgna_pkg::*;

   // config registers
   logic signed [31:0] origin_x_ff, origin_x_in;
   logic signed [31:0] origin_y_ff, origin_y_in;
   logic [30:0]        spacing_x_ff, spacing_x_in;
   logic [30:0]        spacing_y_ff, spacing_y_in;
   logic [30:0]        radius_ff, radius_in;
   logic [10:0]        nodes_x_ff, nodes_x_in;
   logic [10:0]        nodes_y_ff, nodes_y_in;
   logic [61:0]        radius_sq_ff;
   cfg_type            cfg;

   // front end: particle held while its cell is divided out
   logic               req_accept;
   logic [31:0]        part_x_ff, part_y_ff;
   logic [19:0]        part_id_ff;
   logic signed [32:0] off_x, off_y;
   logic               div_idle_x, div_idle_y, div_done_x, div_done_y;
   logic signed [33:0] cell_i, cell_j;

   // candidate pipeline
   logic               pipe_en;
   logic               scan_ready, scan_load;
   cand_type           cand;
   tag_type            dist_tag, sqrt_tag;
   logic [63:0]        dist_sq;
   logic [31:0]        root;

   // pending hit: held until we know whether it closes its run
   logic               pend_valid_ff, pend_valid_in;
   logic               pend_last_ff, pend_last_in;
   logic [71:0]        pend_data_ff, pend_data_in;
   logic               push, new_hit, new_end;

   // output register
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [71:0]        rsp_tdata_ff;
   logic               rsp_tlast_ff;

   // csr writes
   always_comb begin
      origin_x_in  = origin_x_ff;
      origin_y_in  = origin_y_ff;
      spacing_x_in = spacing_x_ff;
      spacing_y_in = spacing_y_ff;
      radius_in    = radius_ff;
      nodes_x_in   = nodes_x_ff;
      nodes_y_in   = nodes_y_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:  origin_x_in  = csr_wdata;
            CSR_ORIGIN_Y:  origin_y_in  = csr_wdata;
            CSR_SPACING_X: spacing_x_in = csr_wdata[30:0];
            CSR_SPACING_Y: spacing_y_in = csr_wdata[30:0];
            CSR_RADIUS:    radius_in    = csr_wdata[30:0];
            CSR_NODES_X:   nodes_x_in   = csr_wdata[10:0];
            CSR_NODES_Y:   nodes_y_in   = csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff  <= '0;
         origin_y_ff  <= '0;
         spacing_x_ff <= 31'd65536;
         spacing_y_ff <= 31'd65536;
         radius_ff    <= 31'd65536;
         nodes_x_ff   <= 11'd1024;
         nodes_y_ff   <= 11'd1024;
      end else begin
         origin_x_ff  <= origin_x_in;
         origin_y_ff  <= origin_y_in;
         spacing_x_ff <= spacing_x_in;
         spacing_y_ff <= spacing_y_in;
         radius_ff    <= radius_in;
         nodes_x_ff   <= nodes_x_in;
         nodes_y_ff   <= nodes_y_in;
      end
      // radius squared is registered from radius_ff, so it settles after it
      radius_sq_ff <= 62'(radius_ff) * 62'(radius_ff);
   end

   always_comb begin
      cfg.origin_x  = origin_x_ff;
      cfg.origin_y  = origin_y_ff;
      cfg.spacing_x = spacing_x_ff;
      cfg.spacing_y = spacing_y_ff;
      cfg.nodes_x   = nodes_x_ff;
      cfg.nodes_y   = nodes_y_ff;
      cfg.radius_sq = radius_sq_ff;
   end

   // front end
   assign req_tready = div_idle_x && div_idle_y;
   assign req_accept = req_tvalid && req_tready;

   assign off_x = $signed({req_tdata[31], req_tdata[31:0]})
                - $signed({origin_x_ff[31], origin_x_ff});
   assign off_y = $signed({req_tdata[63], req_tdata[63:32]})
                - $signed({origin_y_ff[31], origin_y_ff});

   always_ff @(posedge clock) begin
      if (req_accept) begin
         part_x_ff  <= req_tdata[31:0];
         part_y_ff  <= req_tdata[63:32];
         part_id_ff <= req_tdata[83:64];
      end
   end

   pgna_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .num   (off_x),
      .den   (spacing_x_ff),
      .take  (scan_load),
      .idle  (div_idle_x),
      .done  (div_done_x),
      .quot  (cell_i)
   );

   pgna_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .num   (off_y),
      .den   (spacing_y_ff),
      .take  (scan_load),
      .idle  (div_idle_y),
      .done  (div_done_y),
      .quot  (cell_j)
   );

   // whole candidate pipeline moves when the output register can take a word
   assign pipe_en   = !rsp_tvalid_ff || rsp_tready;
   assign scan_load = scan_ready && div_done_x;

   pgna_scan #(
      .WINDOW_REACH (WINDOW_REACH)
   ) u_scan (
      .clock (clock),
      .reset (reset),
      .en    (pipe_en),
      .load  (scan_load),
      .ci    (cell_i),
      .cj    (cell_j),
      .px    (part_x_ff),
      .py    (part_y_ff),
      .pid   (part_id_ff),
      .ready (scan_ready),
      .cand  (cand)
   );

   pgna_dist u_dist (
      .clock (clock),
      .reset (reset),
      .en    (pipe_en),
      .cand  (cand),
      .cfg   (cfg),
      .tag   (dist_tag),
      .sq    (dist_sq)
   );

   pgna_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (pipe_en),
      .tag_in  (dist_tag),
      .sq_in   (dist_sq),
      .tag_out (sqrt_tag),
      .root    (root)
   );

   // run framing: a hit is released when a later hit shows up, or flagged
   // last when the run's final candidate passes
   assign new_hit = sqrt_tag.valid && sqrt_tag.hit;
   assign new_end = sqrt_tag.valid && sqrt_tag.end_run;
   assign push    = pend_valid_ff && (pend_last_ff || new_hit);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_last_in  = pend_last_ff;
      pend_data_in  = pend_data_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (pipe_en) begin
         if (push) begin
            rsp_tvalid_in = 1'b1;
         end
         if (new_hit) begin
            pend_valid_in = 1'b1;
            pend_last_in  = sqrt_tag.end_run;
            pend_data_in  = {root, sqrt_tag.pid, sqrt_tag.node_j, sqrt_tag.node_i};
         end else if (push) begin
            pend_valid_in = 1'b0;
            pend_last_in  = 1'b0;
         end else if (new_end && pend_valid_ff) begin
            pend_last_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         pend_last_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         pend_last_ff  <= pend_last_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      pend_data_ff <= pend_data_in;
      if (pipe_en && push) begin
         rsp_tdata_ff <= pend_data_ff;
         rsp_tlast_ff <= pend_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // both dividers run in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      div_done_x == div_done_y)
      else $error("x and y dividers out of step");

   // an accepted particle occupies the dividers in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_tready)
      else $error("front end free right after accepting a particle");

   // a stalled output freezes the pending hit
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(pend_valid_ff) && $stable(pend_last_ff))
      else $error("pending hit changed during stall");

   // a run close is only ever marked on a held hit
   a_pend_last: assert property (@(posedge clock) disable iff (reset)
      pend_last_ff |-> pend_valid_ff)
      else $error("run close marked without a pending hit");

endmodule

// File: sv/pgna_div.sv
// ---------------------------------------------------------------------------
// pgna_div
// serial floor division of a signed offset by a positive spacing
// ---------------------------------------------------------------------------
module pgna_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [32:0] num,
   input  logic [30:0]        den,
   input  logic               take,
   output logic               idle,
   output logic               done,
   output logic signed [33:0] quot
);
   localparam int STEPS = 33;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [32:0]       numr_ff, numr_in;
   logic [30:0]       rem_ff, rem_in;
   logic [32:0]       quo_ff, quo_in;
   logic [30:0]       den_ff, den_in;
   logic [33:0]       res_ff, res_in;
   logic [31:0]       trial;
   logic              ge;
   logic [33:0]       ures;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      numr_in = numr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      res_in  = res_ff;
      trial   = {rem_ff, numr_ff[32]};
      ge      = trial >= {1'b0, den_ff};
      ures    = '0;
      if (take) begin
         done_in = 1'b0;
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = num[32];
         numr_in = num[32] ? 33'(-num) : 33'(num);
         rem_in  = '0;
         quo_in  = '0;
         den_in  = (den == '0) ? 31'd1 : den;
      end else if (busy_ff) begin
         rem_in  = ge ? 31'(trial - {1'b0, den_ff}) : trial[30:0];
         quo_in  = {quo_ff[31:0], ge};
         numr_in = {numr_ff[31:0], 1'b0};
         cnt_in  = cnt_ff + 6'd1;
         if (cnt_ff == 6'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            ures    = {1'b0, quo_in};
            if (!neg_ff) begin
               res_in = ures;
            end else if (rem_in != '0) begin
               res_in = ~ures;
            end else begin
               res_in = -ures;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      numr_ff <= numr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      res_ff  <= res_in;
   end

   assign idle = !busy_ff && !done_ff;
   assign done = done_ff;
   assign quot = res_ff;

endmodule

// File: sv/pgna_scan.sv
// ---------------------------------------------------------------------------
// pgna_scan
// window scanner, one candidate node per cycle while enabled, rows outer
// ---------------------------------------------------------------------------
module pgna_scan #(
   parameter int WINDOW_REACH = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               load,
   input  logic signed [33:0] ci,
   input  logic signed [33:0] cj,
   input  logic [31:0]        px,
   input  logic [31:0]        py,
   input  logic [19:0]        pid,
   output logic               ready,
   output pgna_pkg::cand_type cand
);
   import pgna_pkg::*;

   localparam int WIDTH = 2 * WINDOW_REACH + 2;
   localparam int CW    = $clog2(WIDTH);

   logic               active_ff, active_in;
   logic [CW-1:0]      cnt_i_ff, cnt_i_in;
   logic [CW-1:0]      cnt_j_ff, cnt_j_in;
   logic signed [33:0] ci_ff, cj_ff;
   logic [31:0]        px_ff, py_ff;
   logic [19:0]        pid_ff;
   logic               last_i, last, step;

   assign last_i = cnt_i_ff == CW'(WIDTH - 1);
   assign last   = last_i && (cnt_j_ff == CW'(WIDTH - 1));
   assign step   = en && active_ff;
   assign ready  = !active_ff || (step && last);

   always_comb begin
      active_in = active_ff | load;
      cnt_i_in  = cnt_i_ff;
      cnt_j_in  = cnt_j_ff;
      if (step) begin
         if (last) begin
            active_in = load;
            cnt_i_in  = '0;
            cnt_j_in  = '0;
         end else if (last_i) begin
            cnt_i_in = '0;
            cnt_j_in = cnt_j_ff + CW'(1);
         end else begin
            cnt_i_in = cnt_i_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_i_ff  <= '0;
         cnt_j_ff  <= '0;
      end else begin
         active_ff <= active_in;
         cnt_i_ff  <= cnt_i_in;
         cnt_j_ff  <= cnt_j_in;
      end
      if (load) begin
         ci_ff  <= ci;
         cj_ff  <= cj;
         px_ff  <= px;
         py_ff  <= py;
         pid_ff <= pid;
      end
   end

   always_comb begin
      cand.valid   = active_ff;
      cand.end_run = last;
      cand.node_i  = {ci_ff[33], ci_ff} + 35'(cnt_i_ff) - 35'(WINDOW_REACH);
      cand.node_j  = {cj_ff[33], cj_ff} + 35'(cnt_j_ff) - 35'(WINDOW_REACH);
      cand.px      = px_ff;
      cand.py      = py_ff;
      cand.pid     = pid_ff;
   end

endmodule

// File: sv/pgna_dist.sv
// ---------------------------------------------------------------------------
// pgna_dist
// grid check, node offset, squares and hit test over five stages
// ---------------------------------------------------------------------------
module pgna_dist (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  pgna_pkg::cand_type cand,
   input  pgna_pkg::cfg_type  cfg,
   output pgna_pkg::tag_type  tag,
   output logic [63:0]        sq
);
   import pgna_pkg::*;

   logic [10:0]        nx_eff, ny_eff;
   logic [30:0]        sx_eff, sy_eff;

   // stage 1: grid check
   tag_type            s1_tag_ff, s1_tag_in;
   logic               s1_in_ff, s1_in_in;
   logic [31:0]        s1_px_ff, s1_py_ff;
   // stage 2: offsets from origin and node products
   tag_type            s2_tag_ff;
   logic               s2_in_ff;
   logic signed [32:0] s2_dxo_ff, s2_dxo_in, s2_dyo_ff, s2_dyo_in;
   logic [40:0]        s2_mx_ff, s2_mx_in, s2_my_ff, s2_my_in;
   // stage 3: magnitudes
   tag_type            s3_tag_ff;
   logic               s3_in_ff;
   logic               s3_sat_ff, s3_sat_in;
   logic [31:0]        s3_ax_ff, s3_ax_in, s3_ay_ff, s3_ay_in;
   logic signed [42:0] dx, dy;
   logic [42:0]        ax, ay;
   // stage 4: squares
   tag_type            s4_tag_ff;
   logic               s4_in_ff, s4_sat_ff;
   logic [63:0]        s4_a_ff, s4_a_in, s4_b_ff, s4_b_in;
   // stage 5: sum and hit test
   tag_type            s5_tag_ff, s5_tag_in;
   logic [63:0]        s5_sq_ff;
   logic [64:0]        sum;

   assign nx_eff = (cfg.nodes_x > NODE_LIMIT) ? NODE_LIMIT : cfg.nodes_x;
   assign ny_eff = (cfg.nodes_y > NODE_LIMIT) ? NODE_LIMIT : cfg.nodes_y;
   assign sx_eff = (cfg.spacing_x == '0) ? 31'd1 : cfg.spacing_x;
   assign sy_eff = (cfg.spacing_y == '0) ? 31'd1 : cfg.spacing_y;

   always_comb begin
      s1_tag_in.valid   = cand.valid;
      s1_tag_in.hit     = 1'b0;
      s1_tag_in.end_run = cand.end_run;
      s1_tag_in.node_i  = cand.node_i[9:0];
      s1_tag_in.node_j  = cand.node_j[9:0];
      s1_tag_in.pid     = cand.pid;
      s1_in_in = !cand.node_i[34] && (cand.node_i[33:0] < 34'(nx_eff))
              && !cand.node_j[34] && (cand.node_j[33:0] < 34'(ny_eff));

      s2_dxo_in = $signed({s1_px_ff[31], s1_px_ff})
                - $signed({cfg.origin_x[31], cfg.origin_x});
      s2_dyo_in = $signed({s1_py_ff[31], s1_py_ff})
                - $signed({cfg.origin_y[31], cfg.origin_y});
      s2_mx_in  = 41'(s1_tag_ff.node_i) * 41'(sx_eff);
      s2_my_in  = 41'(s1_tag_ff.node_j) * 41'(sy_eff);

      dx = $signed({{10{s2_dxo_ff[32]}}, s2_dxo_ff}) - $signed({2'b00, s2_mx_ff});
      dy = $signed({{10{s2_dyo_ff[32]}}, s2_dyo_ff}) - $signed({2'b00, s2_my_ff});
      ax = dx[42] ? 43'(-dx) : 43'(dx);
      ay = dy[42] ? 43'(-dy) : 43'(dy);
      s3_sat_in = (ax[42:32] != '0) || (ay[42:32] != '0);
      s3_ax_in  = ax[31:0];
      s3_ay_in  = ay[31:0];

      s4_a_in = 64'(s3_ax_ff) * 64'(s3_ax_ff);
      s4_b_in = 64'(s3_ay_ff) * 64'(s3_ay_ff);

      sum = {1'b0, s4_a_ff} + {1'b0, s4_b_ff};
      s5_tag_in     = s4_tag_ff;
      s5_tag_in.hit = s4_tag_ff.valid && s4_in_ff && !s4_sat_ff && !sum[64]
                   && (sum[63:0] < {2'b00, cfg.radius_sq});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff.valid <= 1'b0;
         s2_tag_ff.valid <= 1'b0;
         s3_tag_ff.valid <= 1'b0;
         s4_tag_ff.valid <= 1'b0;
         s5_tag_ff.valid <= 1'b0;
      end else if (en) begin
         s1_tag_ff <= s1_tag_in;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         s4_tag_ff <= s3_tag_ff;
         s5_tag_ff <= s5_tag_in;
      end
      if (en) begin
         s1_in_ff  <= s1_in_in;
         s1_px_ff  <= cand.px;
         s1_py_ff  <= cand.py;
         s2_in_ff  <= s1_in_ff;
         s2_dxo_ff <= s2_dxo_in;
         s2_dyo_ff <= s2_dyo_in;
         s2_mx_ff  <= s2_mx_in;
         s2_my_ff  <= s2_my_in;
         s3_in_ff  <= s2_in_ff;
         s3_sat_ff <= s3_sat_in;
         s3_ax_ff  <= s3_ax_in;
         s3_ay_ff  <= s3_ay_in;
         s4_in_ff  <= s3_in_ff;
         s4_sat_ff <= s3_sat_ff;
         s4_a_ff   <= s4_a_in;
         s4_b_ff   <= s4_b_in;
         s5_sq_ff  <= sum[63:0];
      end
   end

   assign tag = s5_tag_ff;
   assign sq  = s5_sq_ff;

endmodule

// File: sv/pgna_sqrt.sv
// ---------------------------------------------------------------------------
// pgna_sqrt
// pipelined floor square root, one result bit per stage
// ---------------------------------------------------------------------------
module pgna_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  pgna_pkg::tag_type tag_in,
   input  logic [63:0]       sq_in,
   output pgna_pkg::tag_type tag_out,
   output logic [31:0]       root
);
   import pgna_pkg::*;

   tag_type     tag_ff [SQRT_STEPS];
   logic [63:0] v_ff   [SQRT_STEPS];
   logic [63:0] r_ff   [SQRT_STEPS];
   logic [63:0] v_in   [SQRT_STEPS];
   logic [63:0] r_in   [SQRT_STEPS];

   always_comb begin
      logic [63:0] v, r, b, t;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         v = (k == 0) ? sq_in : v_ff[(k == 0) ? 0 : k - 1];
         r = (k == 0) ? 64'd0 : r_ff[(k == 0) ? 0 : k - 1];
         b = 64'd1 << (62 - 2 * k);
         t = r + b;
         if (v >= t) begin
            v_in[k] = v - t;
            r_in[k] = (r >> 1) + b;
         end else begin
            v_in[k] = v;
            r_in[k] = r >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            tag_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         tag_ff[0] <= tag_in;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
      if (en) begin
         for (int k = 0; k < SQRT_STEPS; k++) begin
            v_ff[k] <= v_in[k];
            r_ff[k] <= r_in[k];
         end
      end
   end

   assign tag_out = tag_ff[SQRT_STEPS-1];
   assign root    = r_ff[SQRT_STEPS-1][31:0];

endmodule

// File: bench/particle_grid_node_assignment_unit_tb.sv
// ---------------------------------------------------------------------------
// particle_grid_node_assignment_unit_tb
// self-checking bench for the particle grid node assignment unit
// ---------------------------------------------------------------------------
// drives particle words under several grid settings, computes the expected
// run of node hits for each accepted particle and compares every result
// word with the expected one, with random idling on both ports and one long
// result-side hold-off that backs up the pipeline
// ---------------------------------------------------------------------------
module particle_grid_node_assignment_unit_tb;
   import pgna_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REACH = 3;

   typedef struct packed {
      logic        last_hit;
      logic [31:0] distance;
      logic [19:0] hit_id;
      logic [9:0]  node_j;
      logic [9:0]  node_i;
   } hit_word_type;

   // grid settings as the block holds them
   typedef struct {
      logic signed [31:0] ox, oy;
      logic [30:0]        sx, sy, rad;
      logic [10:0]        nx, ny;
   } grid_type;

   // expected hits and the predictor that fills them
   class hit_scoreboard;
      hit_word_type pending_hits[$];
      int           mismatches = 0;

      function automatic longint floor_quot(longint num, longint den);
         longint q;
         q = num / den;
         if ((num % den) != 0 && num < 0) q--;
         return q;
      endfunction

      function automatic longint unsigned int_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function automatic void note_particle(grid_type g, logic [31:0] px_w,
                                            logic [31:0] py_w, logic [19:0] pid);
         longint px, py, sx, sy, nx, ny, ci, cj, i, j, dx, dy;
         longint unsigned ax, ay, a, s, rad2;
         int     first;
         hit_word_type w;
         px = longint'($signed(px_w));
         py = longint'($signed(py_w));
         sx = (g.sx == 0) ? 1 : longint'(g.sx);
         sy = (g.sy == 0) ? 1 : longint'(g.sy);
         nx = (g.nx > NODE_LIMIT) ? 1024 : longint'(g.nx);
         ny = (g.ny > NODE_LIMIT) ? 1024 : longint'(g.ny);
         rad2 = longint'(g.rad) * longint'(g.rad);
         ci = floor_quot(px - longint'(g.ox), sx);
         cj = floor_quot(py - longint'(g.oy), sy);
         first = pending_hits.size();
         for (longint oj = -REACH; oj <= REACH + 1; oj++) begin
            j = cj + oj;
            if (j < 0 || j >= ny) continue;
            for (longint oi = -REACH; oi <= REACH + 1; oi++) begin
               i = ci + oi;
               if (i < 0 || i >= nx) continue;
               dx = px - (longint'(g.ox) + i * sx);
               dy = py - (longint'(g.oy) + j * sy);
               ax = (dx < 0) ? -dx : dx;
               ay = (dy < 0) ? -dy : dy;
               // any axis gap of 2^32 or more can never be a hit
               if (ax >= 64'h1_0000_0000 || ay >= 64'h1_0000_0000) continue;
               a = ax * ax;
               s = a + ay * ay;
               if (s < a || s >= rad2) continue;
               w.node_i   = i[9:0];
               w.node_j   = j[9:0];
               w.hit_id   = pid;
               w.distance = 32'(int_root(s));
               w.last_hit = 1'b0;
               pending_hits = {pending_hits, w};
            end
         end
         if (pending_hits.size() > first)
            pending_hits[pending_hits.size() - 1].last_hit = 1'b1;
      endfunction

      function automatic void check_hit(hit_word_type got);
         hit_word_type exp_w;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
            return;
         end
         exp_w = pending_hits.pop_front();
         if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp i=%0d j=%0d id=%h d=%h last=%b, got i=%0d j=%0d id=%h d=%h last=%b",
                        exp_w.node_i, exp_w.node_j, exp_w.hit_id, exp_w.distance,
                        exp_w.last_hit, got.node_i, got.node_j, got.hit_id,
                        got.distance, got.last_hit);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = CSR_ORIGIN_X;
   logic [31:0] csr_wdata = '0;

   hit_scoreboard sb = new();
   grid_type grid;
   bit     calm = 1'b0;       // last part of the run: no idling
   bit     hold_off = 1'b0;   // long result-side stall requested
   bit     hold_done = 1'b0;

   always #5 clock = ~clock;

   particle_grid_node_assignment_unit #(.WINDOW_REACH(REACH)) i_dut (.*);

   // result side: sample at the rising edge, compare against the oldest hit
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_hit({rsp_tlast, rsp_tdata});
   end

   // result side ready: random bursts of stall, plus one long hold-off
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            hold_off  = 1'b0;
            hold_done = 1'b1;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(1, 19);
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(1, 30);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_ORIGIN_X:  grid.ox  = val;
         CSR_ORIGIN_Y:  grid.oy  = val;
         CSR_SPACING_X: grid.sx  = val[30:0];
         CSR_SPACING_Y: grid.sy  = val[30:0];
         CSR_RADIUS:    grid.rad = val[30:0];
         CSR_NODES_X:   grid.nx  = val[10:0];
         default:       grid.ny  = val[10:0];
      endcase
   endtask

   task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] sx,
                           logic [31:0] sy, logic [31:0] rad, logic [31:0] nx,
                           logic [31:0] ny);
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_SPACING_X, sx);
      write_reg(CSR_SPACING_Y, sy);
      write_reg(CSR_RADIUS, rad);
      write_reg(CSR_NODES_X, nx);
      write_reg(CSR_NODES_Y, ny);
   endtask

   // send one particle word; valid stays high back to back unless idling
   task automatic send_particle(logic [31:0] px, logic [31:0] py, logic [19:0] pid);
      int n;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         n = $urandom_range(1, 19);
         repeat (n) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, pid, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_particle(grid, px, py, pid);
      @(negedge clock);
   endtask

   // wait for every expected hit, then the pipeline latency of empty runs
   task automatic drain;
      req_tvalid <= 1'b0;
      while (sb.pending_hits.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   // random particle near the grid so that runs are mostly non-empty
   task automatic random_particle;
      longint px, py, span_x, span_y;
      logic [31:0] rx, ry;
      span_x = longint'(grid.sx) * (longint'(grid.nx) + 4);
      span_y = longint'(grid.sy) * (longint'(grid.ny) + 4);
      if ($urandom_range(0, 9) == 0) begin
         rx = $urandom();
         ry = $urandom();
      end else begin
         px = longint'(grid.ox) - 2 * longint'(grid.sx)
              + (longint'({$urandom(), $urandom()} & 64'h7fff_ffff_ffff) % span_x);
         py = longint'(grid.oy) - 2 * longint'(grid.sy)
              + (longint'({$urandom(), $urandom()} & 64'h7fff_ffff_ffff) % span_y);
         rx = px[31:0];
         ry = py[31:0];
      end
      send_particle(rx, ry, 20'($urandom()));
   endtask

   initial begin
      grid = '{ox: 0, oy: 0, sx: 65536, sy: 65536, rad: 65536, nx: 1024, ny: 1024};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset settings, field extremes, grid corners and edges
      send_particle(32'h0000_8000, 32'h0000_8000, 20'h00000);
      send_particle(32'h0000_0000, 32'h0000_0000, 20'hFFFFF);
      send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'h5A5A5);
      send_particle(32'h8000_0000, 32'h8000_0000, 20'hA5A5A);
      send_particle(32'h03FF_0000, 32'h03FF_0000, 20'h12345);
      send_particle(32'hFFFF_0000, 32'h0001_0000, 20'h00001);
      send_particle(32'h8000_0000, 32'h7FFF_FFFF, 20'h54321);
      drain();

      // wide radius: every in-grid window node is a hit; counts above the limit
      set_grid(32'hFFF0_0000, 32'h0000_0000, 32'h0001_0000, 32'h0002_0000,
               32'h7FFF_FFFF, 32'h7FF, 32'h7FF);
      send_particle(32'h0000_0000, 32'h0001_8000, 20'hABCDE);
      send_particle(32'h7FFF_FFFF, 32'h8000_0000, 20'h0F0F0);
      send_particle(32'h0001_0000, 32'h7FFF_0000, 20'hF0F0F);
      drain();

      // zero spacing and zero radius
      set_grid(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd16, 32'd16);
      send_particle(32'd5, 32'd5, 20'h11111);
      drain();
      write_reg(CSR_RADIUS, 32'd3);
      send_particle(32'd5, 32'd5, 20'h22222);
      send_particle(32'hFFFF_FFFF, 32'd2, 20'h33333);
      drain();

      // zero node counts, then one node only
      set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF,
               32'd0, 32'd0);
      send_particle(32'h8000_0000, 32'h7FFF_FFFF, 20'h44444);
      drain();
      write_reg(CSR_NODES_X, 32'd1);
      write_reg(CSR_NODES_Y, 32'd1);
      send_particle(32'h8000_0000, 32'h7FFF_FFFF, 20'h55555);
      send_particle(32'h7FFF_FFFF, 32'h8000_0000, 20'h66666);
      drain();
      // nodes beyond the window stay unreported despite the radius
      write_reg(CSR_NODES_X, 32'd1024);
      send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'h77777);
      drain();

      // random phases under several settings
      for (int ph = 0; ph < 6; ph++) begin
         set_grid($urandom(), $urandom(), $urandom_range(1, 32'h0004_0000),
                  $urandom_range(1, 32'h0004_0000), 32'h0,
                  $urandom_range(1, 1024), $urandom_range(1, 1024));
         write_reg(CSR_RADIUS, 32'((longint'(grid.sx) + grid.sy)
                   * $urandom_range(1, 4) / 2 + $urandom_range(0, 65535)));
         if (ph == 5) calm = 1'b1;
         for (int k = 0; k < 27; k++) begin
            if (ph == 1 && k == 3) hold_off = 1'b1;
            random_particle();
         end
         drain();
      end

      if (sb.mismatches == 0 && sb.pending_hits.size() == 0 && hold_done)
         $display("particle_grid_node_assignment_unit test passed");
      else
         $display("particle_grid_node_assignment_unit test failed");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("particle_grid_node_assignment_unit test failed");
      $finish;
   end

endmodule
